// File: design/frdrm_pkg.sv
package frdrm_pkg;

  localparam int RuleDepth   = 256;
  localparam int RuleAw      = 8;
  localparam int ParamDepth  = 1024;
  localparam int ParamAw     = 10;
  localparam int ColumnLimit = 512;

  localparam logic [35:0] HashFirst = 36'hF00001388;
  localparam logic [35:0] HashLast  = 36'hF0000138B;

  localparam logic [1:0] ActByte  = 2'd0;
  localparam logic [1:0] ActRule  = 2'd1;
  localparam logic [1:0] ActParam = 2'd2;

  localparam logic [1:0] KindNone = 2'd0;
  localparam logic [1:0] KindCol  = 2'd1;
  localparam logic [1:0] KindHash = 2'd2;

  typedef enum logic [3:0] {
    OpNone, OpGt, OpGe, OpLt, OpLe, OpEq, OpNe, OpInside, OpOutside,
    OpMaskAny, OpMaskEq, OpInList, OpNotInList
  } rule_op_e;

  typedef enum logic [1:0] {
    PhSize, PhId, PhKey, PhValue
  } phase_e;

  typedef enum logic [3:0] {
    StIdle, StSearch, StSearchWait, StSearchChk, StFinal, StFinalChk,
    StP0, StP0Chk, StP1, StP1Chk, StList, StListChk, StOut
  } state_e;

  typedef struct packed {
    logic [10:0] count;
    logic [9:0]  first;
    logic        is_bool;
    logic [8:0]  column;
    logic [3:0]  op;
  } rule_act_t;

endpackage

// File: design/feature_record_decode_rule_match_top.sv
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_stall_o | action, stream, rule and param fields
// output  | out       | out_valid_o/out_stall_i| write_kind, target_column, hash_word,
//         |           |                       | write_value, record_end
// config  | in        | cfg_we_i              | cfg_data_i (rules_in_use)
// An entry end with a rule lookup runs StSearch, StSearchWait and StSearchChk per
// binary search step (at most 9 steps), then a read and a check state per parameter
// word read; list ops read up to param_count words over the one parameter port.
// Reset clears parse and control state; rule and parameter memories are not cleared.
// A result waits in the output register; input stalls only while busy or while
// an earlier result is still held.
module feature_record_decode_rule_match_top
  import frdrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [7:0]  stream_byte_i,
  input  logic [7:0]  rule_slot_i,
  input  logic [35:0] rule_key_i,
  input  logic [3:0]  rule_op_i,
  input  logic [8:0]  rule_column_i,
  input  logic        rule_is_bool_i,
  input  logic [9:0]  param_first_i,
  input  logic [10:0] param_count_i,
  input  logic [9:0]  param_slot_i,
  input  logic [31:0] param_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  write_kind_o,
  output logic [8:0]  target_column_o,
  output logic [1:0]  hash_word_o,
  output logic [31:0] write_value_o,
  output logic        record_end_o
);

  logic [35:0] key_mem [RuleDepth];
  logic [34:0] act_mem [RuleDepth];
  logic [31:0] par_mem [ParamDepth];

  logic [RuleAw-1:0]  key_ra, act_ra;
  logic [ParamAw-1:0] par_ra;
  logic [35:0] key_rd_q;
  logic [34:0] act_rd_q;
  logic [31:0] par_rd_q;

  logic [8:0]  rules_q;
  phase_e      phase_q, phase_d;
  logic [1:0]  sz_cnt_q, sz_cnt_d;
  logic [31:0] rsize_q, rsize_d;
  logic [31:0] consumed_q, consumed_d;
  logic [35:0] ekey_q, ekey_d;
  logic [2:0]  klen_q, klen_d;
  logic [2:0]  kleft_q, kleft_d;
  logic [1:0]  vmode_q, vmode_d;
  logic [31:0] vacc_q, vacc_d;
  logic [2:0]  vleft_q, vleft_d;

  state_e      st_q, st_d;
  logic [8:0]  lo_q, lo_d, hi_q, hi_d;
  logic [31:0] val_q, val_d;
  logic        end_q, end_d;
  rule_act_t   act_q, act_d;
  logic [31:0] p0_q, p0_d;
  logic [10:0] idx_q, idx_d;
  logic        seen_q, seen_d;

  logic        ov_q, ov_d;
  logic [1:0]  okind_q, okind_d;
  logic [8:0]  ocol_q, ocol_d;
  logic [1:0]  ohw_q, ohw_d;
  logic [31:0] oval_q, oval_d;
  logic        oend_q, oend_d;

  logic        in_acc, out_acc;
  logic [8:0]  mid, n_clamp;
  logic [1:0]  kidx, vidx;
  logic        fin;
  logic [31:0] fin_val;
  logic [31:0] cons_inc;
  logic        hit;

  assign out_acc   = ov_q && !out_stall_i;
  assign in_stall_o = (st_q != StIdle) || (ov_q && !out_acc);
  assign in_acc    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc && action_i == ActRule) begin
      key_mem[rule_slot_i] <= rule_key_i;
      act_mem[rule_slot_i] <= {param_count_i, param_first_i, rule_is_bool_i,
                               rule_column_i, rule_op_i};
    end
    if (in_acc && action_i == ActParam) begin
      par_mem[param_slot_i] <= param_value_i;
    end
    key_rd_q <= key_mem[key_ra];
    act_rd_q <= act_mem[act_ra];
    par_rd_q <= par_mem[par_ra];
  end

  assign n_clamp = (rules_q > 9'(RuleDepth)) ? 9'(RuleDepth) : rules_q;
  assign mid     = 9'((10'(lo_q) + 10'(hi_q)) >> 1);
  assign key_ra  = mid[RuleAw-1:0];
  assign act_ra  = lo_q[RuleAw-1:0];
  assign par_ra  = (st_q == StP1) ? act_q.first + 10'd1 :
                   (st_q == StList) ? act_q.first + idx_q[ParamAw-1:0] : act_q.first;

  always_comb begin
    phase_d = phase_q; sz_cnt_d = sz_cnt_q; rsize_d = rsize_q;
    consumed_d = consumed_q; ekey_d = ekey_q; klen_d = klen_q; kleft_d = kleft_q;
    vmode_d = vmode_q; vacc_d = vacc_q; vleft_d = vleft_q;
    st_d = st_q; lo_d = lo_q; hi_d = hi_q; val_d = val_q; end_d = end_q;
    act_d = act_q; p0_d = p0_q; idx_d = idx_q; seen_d = seen_q;
    ov_d = ov_q && !out_acc; okind_d = okind_q; ocol_d = ocol_q; ohw_d = ohw_q;
    oval_d = oval_q; oend_d = oend_q;
    fin = 1'b0; fin_val = '0; hit = 1'b0;
    cons_inc = consumed_q + 32'd1;
    kidx = 2'(klen_q - kleft_q);
    vidx = 2'(((vmode_q == 2'd1) ? 3'd4 : 3'd1) - vleft_q);

    unique case (st_q)
      StIdle: begin
        if (in_acc && action_i == ActByte) begin
          unique case (phase_q)
            PhSize: begin
              rsize_d = (sz_cnt_q == 2'd0) ? 32'(stream_byte_i) :
                        rsize_q | (32'(stream_byte_i) << {sz_cnt_q, 3'b000});
              sz_cnt_d = sz_cnt_q + 2'd1;
              if (sz_cnt_q == 2'd3) begin
                consumed_d = '0;
                if (rsize_d == 32'd0) begin
                  ov_d = 1'b1; okind_d = KindNone; ocol_d = '0; ohw_d = '0;
                  oval_d = '0; oend_d = 1'b1;
                end else begin
                  phase_d = PhId;
                end
              end
            end
            PhId: begin
              consumed_d = cons_inc;
              ekey_d = {stream_byte_i[3:0], 32'd0};
              klen_d = 3'(stream_byte_i[5:4]) + 3'd1;
              kleft_d = 3'(stream_byte_i[5:4]) + 3'd1;
              vmode_d = stream_byte_i[7:6];
              vacc_d = '0;
              phase_d = PhKey;
            end
            PhKey: begin
              consumed_d = cons_inc;
              ekey_d = ekey_q | (36'(stream_byte_i) << {kidx, 3'b000});
              kleft_d = kleft_q - 3'd1;
              if (kleft_q == 3'd1) begin
                if (!vmode_q[1]) begin
                  vleft_d = vmode_q[0] ? 3'd4 : 3'd1;
                  phase_d = PhValue;
                end else begin
                  fin = 1'b1;
                  fin_val = vmode_q[0] ? 32'hFFFFFFFF : 32'd0;
                end
              end
            end
            default: begin
              consumed_d = cons_inc;
              vacc_d = vacc_q | (32'(stream_byte_i) << {vidx, 3'b000});
              vleft_d = vleft_q - 3'd1;
              if (vleft_q == 3'd1) begin
                fin = 1'b1;
                fin_val = vacc_d;
              end
            end
          endcase
          if (fin) begin
            end_d = (cons_inc >= rsize_q);
            phase_d = end_d ? PhSize : PhId;
            val_d = fin_val;
            lo_d = '0;
            hi_d = n_clamp;
            if (ekey_d >= HashFirst && ekey_d <= HashLast) begin
              ov_d = 1'b1; okind_d = KindHash; ocol_d = '0;
              ohw_d = 2'(ekey_d - HashFirst); oval_d = fin_val; oend_d = end_d;
            end else begin
              st_d = StSearch;
            end
          end
        end
      end
      StSearch: begin
        st_d = (lo_q < hi_q) ? StSearchWait : StFinal;
      end
      StSearchWait: st_d = StSearchChk;
      StSearchChk: begin
        if (key_rd_q < ekey_q) lo_d = mid + 9'd1;
        else hi_d = mid;
        st_d = StSearch;
      end
      StFinal: begin
        // act_mem read at lo; key compare needs key at lo too: hi is lo now
        st_d = (lo_q < n_clamp) ? StFinalChk : StOut;
        hit = 1'b0;
        if (lo_q >= n_clamp) begin
          okind_d = KindNone;
        end
      end
      StFinalChk: begin
        act_d = rule_act_t'(act_rd_q);
        idx_d = '0; seen_d = 1'b0;
        if (key_rd_q != ekey_q || 10'(act_rd_q[12:4]) >= 10'(ColumnLimit) ||
            act_rd_q[3:0] > 4'(OpNotInList)) begin
          st_d = StOut; okind_d = KindNone;
        end else if (act_rd_q[3:0] == 4'(OpNone)) begin
          st_d = StOut; okind_d = KindCol; oval_d = act_rd_q[13] ? 32'd1 : val_q;
        end else if (act_rd_q[3:0] == 4'(OpInList) ||
                     act_rd_q[3:0] == 4'(OpNotInList)) begin
          st_d = StList;
        end else begin
          st_d = StP0;
        end
      end
      StP0: st_d = StP0Chk;
      StP0Chk: begin
        p0_d = par_rd_q;
        if (act_q.op == 4'(OpInside) || act_q.op == 4'(OpOutside) ||
            act_q.op == 4'(OpMaskEq)) begin
          st_d = StP1;
        end else begin
          unique case (act_q.op)
            4'(OpGt): hit = val_q > par_rd_q;
            4'(OpGe): hit = val_q >= par_rd_q;
            4'(OpLt): hit = val_q < par_rd_q;
            4'(OpLe): hit = val_q <= par_rd_q;
            4'(OpEq): hit = val_q == par_rd_q;
            4'(OpNe): hit = val_q != par_rd_q;
            default:  hit = (val_q & par_rd_q) != 32'd0;
          endcase
          okind_d = hit ? KindCol : KindNone; oval_d = 32'd1; st_d = StOut;
        end
      end
      StP1: st_d = StP1Chk;
      StP1Chk: begin
        unique case (act_q.op)
          4'(OpInside):  hit = val_q >= p0_q && val_q <= par_rd_q;
          4'(OpOutside): hit = val_q < p0_q || val_q > par_rd_q;
          default:       hit = (val_q & p0_q) == par_rd_q;
        endcase
        okind_d = hit ? KindCol : KindNone; oval_d = 32'd1; st_d = StOut;
      end
      StList: begin
        if (seen_q || idx_q >= act_q.count) begin
          hit = (act_q.op == 4'(OpInList)) ? seen_q : !seen_q;
          okind_d = hit ? KindCol : KindNone; oval_d = 32'd1; st_d = StOut;
        end else begin
          st_d = StListChk;
        end
      end
      StListChk: begin
        seen_d = (val_q == par_rd_q);
        idx_d = idx_q + 11'd1;
        st_d = StList;
      end
      default: begin
        if (!ov_d) begin
          if (okind_q == KindCol || end_q) begin
            ov_d = 1'b1;
            oend_d = end_q;
            ohw_d = '0;
            if (okind_q == KindCol) begin
              ocol_d = act_q.column;
            end else begin
              ocol_d = '0; oval_d = '0; okind_d = KindNone;
            end
          end
          st_d = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_q <= '0; phase_q <= PhSize; sz_cnt_q <= '0; rsize_q <= '0;
      consumed_q <= '0; ekey_q <= '0; klen_q <= '0; kleft_q <= '0;
      vmode_q <= '0; vacc_q <= '0; vleft_q <= '0;
      st_q <= StIdle; ov_q <= 1'b0; okind_q <= KindNone;
    end else begin
      if (cfg_we_i) rules_q <= cfg_data_i;
      phase_q <= phase_d; sz_cnt_q <= sz_cnt_d; rsize_q <= rsize_d;
      consumed_q <= consumed_d; ekey_q <= ekey_d; klen_q <= klen_d;
      kleft_q <= kleft_d; vmode_q <= vmode_d; vacc_q <= vacc_d; vleft_q <= vleft_d;
      st_q <= st_d; ov_q <= ov_d; okind_q <= okind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; val_q <= val_d; end_q <= end_d; act_q <= act_d;
    p0_q <= p0_d; idx_q <= idx_d; seen_q <= seen_d;
    ocol_q <= ocol_d; ohw_q <= ohw_d; oval_q <= oval_d; oend_q <= oend_d;
  end

  assign out_valid_o     = ov_q;
  assign write_kind_o    = okind_q;
  assign target_column_o = ocol_q;
  assign hash_word_o     = ohw_q;
  assign write_value_o   = oval_q;
  assign record_end_o    = oend_q;

endmodule

// File: tb/sv/feature_record_decode_rule_match_checker.sv
`timescale 1ns / 1ps

module feature_record_decode_rule_match_checker
  import frdrm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  stream_byte_i,
  input  logic [7:0]  rule_slot_i,
  input  logic [35:0] rule_key_i,
  input  logic [3:0]  rule_op_i,
  input  logic [8:0]  rule_column_i,
  input  logic        rule_is_bool_i,
  input  logic [9:0]  param_first_i,
  input  logic [10:0] param_count_i,
  input  logic [9:0]  param_slot_i,
  input  logic [31:0] param_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  write_kind_i,
  input  logic [8:0]  target_column_i,
  input  logic [1:0]  hash_word_i,
  input  logic [31:0] write_value_i,
  input  logic        record_end_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  col;
    logic [1:0]  hw;
    logic [31:0] val;
    logic        last;
  } col_write_t;

  col_write_t  writes_due[$];
  logic [35:0] rule_keys_m[RuleDepth];
  rule_act_t   rule_acts_m[RuleDepth];
  logic [31:0] params_m[ParamDepth];

  logic [8:0]  rules_used;
  phase_e      phase;
  int          size_taken;
  logic [31:0] rec_size;
  logic [31:0] consumed;
  logic [35:0] ekey;
  int          klen;
  int          kleft;
  int          vmode;
  int          vleft;
  logic [31:0] vacc;

  function automatic logic [31:0] pword(logic [9:0] first, int i);
    return params_m[10'(first + i)];
  endfunction

  function automatic bit rule_hit(input logic [35:0] key, input logic [31:0] v,
                                  output logic [8:0] col, output logic [31:0] val);
    int        n;
    int        lo;
    int        hi;
    int        mid;
    rule_act_t a;
    bit        hit;
    bit        seen;
    n = (rules_used > RuleDepth) ? RuleDepth : rules_used;
    lo = 0;
    hi = n;
    col = '0;
    val = '0;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (rule_keys_m[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    if (lo >= n || rule_keys_m[lo] != key) return 0;
    a = rule_acts_m[lo];
    hit = 0;
    val = 32'd1;
    case (a.op)
      OpNone: begin
        hit = 1;
        if (!a.is_bool) val = v;
      end
      OpGt:      hit = v > pword(a.first, 0);
      OpGe:      hit = v >= pword(a.first, 0);
      OpLt:      hit = v < pword(a.first, 0);
      OpLe:      hit = v <= pword(a.first, 0);
      OpEq:      hit = v == pword(a.first, 0);
      OpNe:      hit = v != pword(a.first, 0);
      OpInside:  hit = v >= pword(a.first, 0) && v <= pword(a.first, 1);
      OpOutside: hit = v < pword(a.first, 0) || v > pword(a.first, 1);
      OpMaskAny: hit = (v & pword(a.first, 0)) != 0;
      OpMaskEq:  hit = (v & pword(a.first, 0)) == pword(a.first, 1);
      OpInList, OpNotInList: begin
        seen = 0;
        for (int i = 0; i < a.count; i++) begin
          if (v == pword(a.first, i)) begin
            seen = 1;
            break;
          end
        end
        hit = (a.op == OpInList) ? seen : !seen;
      end
      default: hit = 0;
    endcase
    if (hit) col = a.column;
    else val = '0;
    return hit;
  endfunction

  task automatic finish_entry(logic [31:0] v);
    col_write_t  w;
    logic [8:0]  c;
    logic [31:0] x;
    w = '0;
    if (ekey >= HashFirst && ekey <= HashLast) begin
      w.kind = KindHash;
      w.hw   = 2'(ekey - HashFirst);
      w.val  = v;
    end else if (rule_hit(ekey, v, c, x)) begin
      w.kind = KindCol;
      w.col  = c;
      w.val  = x;
    end
    w.last = consumed >= rec_size;
    phase  = w.last ? PhSize : PhId;
    if (w.kind != KindNone || w.last) writes_due.push_back(w);
  endtask

  task automatic take_byte(logic [7:0] b);
    col_write_t w;
    case (phase)
      PhSize: begin
        if (size_taken == 0) rec_size = '0;
        rec_size   = rec_size | (32'(b) << (8 * size_taken));
        size_taken = (size_taken + 1) % 4;
        if (size_taken == 0) begin
          consumed = '0;
          if (rec_size == 0) begin
            w      = '0;
            w.last = 1'b1;
            writes_due.push_back(w);
          end else begin
            phase = PhId;
          end
        end
      end
      PhId: begin
        consumed++;
        ekey  = {b[3:0], 32'd0};
        klen  = int'(b[5:4]) + 1;
        kleft = klen;
        vmode = int'(b[7:6]);
        vacc  = '0;
        phase = PhKey;
      end
      PhKey: begin
        consumed++;
        ekey = ekey | (36'(b) << (8 * (klen - kleft)));
        kleft--;
        if (kleft == 0) begin
          if (vmode < 2) begin
            vleft = (vmode == 1) ? 4 : 1;
            phase = PhValue;
          end else begin
            finish_entry((vmode == 3) ? 32'hFFFF_FFFF : 32'd0);
          end
        end
      end
      default: begin
        consumed++;
        vacc = vacc | (32'(b) << (8 * (((vmode == 1) ? 4 : 1) - vleft)));
        vleft--;
        if (vleft == 0) finish_entry(vacc);
      end
    endcase
  endtask

  always @(posedge clk_i) begin
    col_write_t w;
    if (!rst_ni) begin
      rules_used = '0;
      phase      = PhSize;
      size_taken = 0;
      rec_size   = '0;
      consumed   = '0;
      ekey       = '0;
      klen       = 0;
      kleft      = 0;
      vmode      = 0;
      vleft      = 0;
      vacc       = '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (writes_due.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("unexpected write: kind %0d col %0d hw %0d val %h end %0d",
                     write_kind_i, target_column_i, hash_word_i, write_value_i,
                     record_end_i);
        end else begin
          w = writes_due.pop_front();
          if (write_kind_i !== w.kind || target_column_i !== w.col ||
              hash_word_i !== w.hw || write_value_i !== w.val ||
              record_end_i !== w.last) begin
            errors_o++;
            if (errors_o <= 10)
              $display({"write mismatch: exp kind %0d col %0d hw %0d val %h end %0d, ",
                        "got kind %0d col %0d hw %0d val %h end %0d"},
                       w.kind, w.col, w.hw, w.val, w.last, write_kind_i,
                       target_column_i, hash_word_i, write_value_i, record_end_i);
          end
        end
      end
      if (cfg_we_i) rules_used = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        case (action_i)
          ActRule: begin
            rule_keys_m[rule_slot_i] = rule_key_i;
            rule_acts_m[rule_slot_i] = {param_count_i, param_first_i, rule_is_bool_i,
                                        rule_column_i, rule_op_i};
          end
          ActParam: params_m[param_slot_i] = param_value_i;
          ActByte:  take_byte(stream_byte_i);
          default: ;
        endcase
      end
    end
    pending_o = writes_due.size();
  end

endmodule

// File: tb/sv/feature_record_decode_rule_match_top_test.sv
`timescale 1ns / 1ps

module feature_record_decode_rule_match_top_test
  import frdrm_pkg::*;
();

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [8:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  action_i = '0;
  logic [7:0]  stream_byte_i = '0;
  logic [7:0]  rule_slot_i = '0;
  logic [35:0] rule_key_i = '0;
  logic [3:0]  rule_op_i = '0;
  logic [8:0]  rule_column_i = '0;
  logic        rule_is_bool_i = 1'b0;
  logic [9:0]  param_first_i = '0;
  logic [10:0] param_count_i = '0;
  logic [9:0]  param_slot_i = '0;
  logic [31:0] param_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  write_kind_o;
  logic [8:0]  target_column_o;
  logic [1:0]  hash_word_o;
  logic [31:0] write_value_o;
  logic        record_end_o;

  int errors;
  int pending;

  logic [1:0]  st_action;
  logic [7:0]  st_byte;
  logic [7:0]  st_slot;
  logic [35:0] st_key;
  logic [3:0]  st_op;
  logic [8:0]  st_col;
  logic        st_bool;
  logic [9:0]  st_first;
  logic [10:0] st_count;
  logic [9:0]  st_pslot;
  logic [31:0] st_pval;

  logic [35:0] tb_keys[RuleDepth];
  logic [9:0]  tb_first[RuleDepth];
  logic [31:0] tb_params[ParamDepth];
  int          nrules;
  int          burst_left;
  bit          hold_req;

  feature_record_decode_rule_match_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i, .in_stall_o,
    .action_i, .stream_byte_i, .rule_slot_i, .rule_key_i, .rule_op_i,
    .rule_column_i, .rule_is_bool_i, .param_first_i, .param_count_i,
    .param_slot_i, .param_value_i, .out_valid_o, .out_stall_i, .write_kind_o,
    .target_column_o, .hash_word_o, .write_value_o, .record_end_o
  );

  feature_record_decode_rule_match_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i,
    .in_stall_i(in_stall_o), .action_i, .stream_byte_i, .rule_slot_i,
    .rule_key_i, .rule_op_i, .rule_column_i, .rule_is_bool_i, .param_first_i,
    .param_count_i, .param_slot_i, .param_value_i, .out_valid_i(out_valid_o),
    .out_stall_i, .write_kind_i(write_kind_o), .target_column_i(target_column_o),
    .hash_word_i(hash_word_o), .write_value_i(write_value_o),
    .record_end_i(record_end_o), .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: stall pattern in stretches, plus one long hold-off on request
  initial begin
    int mode;
    int left;
    int hold;
    mode = 0;
    left = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) begin
        hold = 600;
        hold_req = 0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(20, 200);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic rand_fields();
    st_action = 2'($urandom);
    st_byte   = 8'($urandom);
    st_slot   = 8'($urandom);
    st_key    = 36'({$urandom, $urandom});
    st_op     = 4'($urandom);
    st_col    = 9'($urandom);
    st_bool   = 1'($urandom);
    st_first  = 10'($urandom);
    st_count  = 11'($urandom);
    st_pslot  = 10'($urandom);
    st_pval   = $urandom;
  endtask

  task automatic push();
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    action_i       <= st_action;
    stream_byte_i  <= st_byte;
    rule_slot_i    <= st_slot;
    rule_key_i     <= st_key;
    rule_op_i      <= st_op;
    rule_column_i  <= st_col;
    rule_is_bool_i <= st_bool;
    param_first_i  <= st_first;
    param_count_i  <= st_count;
    param_slot_i   <= st_pslot;
    param_value_i  <= st_pval;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_byte(logic [7:0] b);
    rand_fields();
    st_action = ActByte;
    st_byte   = b;
    push();
  endtask

  task automatic write_param(int slot, logic [31:0] v);
    rand_fields();
    st_action = ActParam;
    st_pslot  = 10'(slot);
    st_pval   = v;
    tb_params[slot] = v;
    push();
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
  endtask

  task automatic set_rules_in_use(logic [8:0] v);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_rules(int n, bit directed);
    logic [35:0] k;
    k = (n < 16) ? {4'($urandom_range(0, 14)), 32'($urandom)} : 36'($urandom >> 8);
    for (int i = 0; i < n; i++) begin
      rand_fields();
      if (i > 0)
        k = k + (($urandom_range(0, 3) == 0) ? 36'($urandom >> 5)
                                             : 36'($urandom_range(1, 3)));
      tb_keys[i]  = k;
      st_action   = ActRule;
      st_slot     = 8'(i);
      st_key      = k;
      st_op       = directed ? 4'(i)
                             : (($urandom_range(0, 9) == 0) ? 4'($urandom_range(13, 15))
                                                            : 4'($urandom_range(0, 12)));
      tb_first[i] = st_first;
      if ($urandom_range(0, 60) == 0)
        st_count = ($urandom_range(0, 1) != 0) ? 11'd1024
                                               : 11'($urandom_range(512, 1023));
      else
        st_count = 11'($urandom_range(0, 6));
      push();
    end
    nrules = n;
  endtask

  function automatic logic [35:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50 && nrules > 0) return tb_keys[$urandom_range(0, nrules - 1)];
    if (r < 55 && nrules > 0) return tb_keys[$urandom_range(0, nrules - 1)] + 36'd1;
    if (r < 70) return HashFirst + 36'($urandom_range(0, 3));
    if (r < 74) return ($urandom_range(0, 1) != 0) ? HashFirst - 36'd1 : HashLast + 36'd1;
    return {4'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [31:0] pick_value(logic [35:0] key);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return tb_params[$urandom_range(0, ParamDepth - 1)];
    if (r < 50)
      return tb_params[$urandom_range(0, ParamDepth - 1)] + 32'($urandom_range(0, 2)) - 1;
    if (r < 55) return '0;
    if (r < 60) return '1;
    return $urandom;
  endfunction

  task automatic add_entry(ref logic [7:0] q[$], input logic [35:0] key,
                           input logic [31:0] v);
    int mode;
    int minlen;
    int len;
    mode   = $urandom_range(0, 3);
    minlen = (key[31:24] != 0) ? 4 : (key[23:16] != 0) ? 3 : (key[15:8] != 0) ? 2 : 1;
    len    = $urandom_range(minlen, 4);
    q.push_back({2'(mode), 2'(len - 1), key[35:32]});
    for (int j = 0; j < len; j++) q.push_back(key[8*j +: 8]);
    if (mode == 0) q.push_back(v[7:0]);
    if (mode == 1) for (int j = 0; j < 4; j++) q.push_back(v[8*j +: 8]);
  endtask

  // style: 0 exact size, 1 short size (entry overruns), 2 empty, 3 garbage body
  task automatic send_record(ref logic [7:0] q[$], input int style);
    logic [31:0] sz;
    if (style == 2) q.delete();
    if (style == 3) begin
      q.delete();
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
    end
    sz = q.size();
    if (style == 1 && q.size() > 1) sz = $urandom_range(1, q.size() - 1);
    for (int j = 0; j < 4; j++) send_byte(sz[8*j +: 8]);
    foreach (q[j]) send_byte(q[j]);
  endtask

  task automatic random_records(int budget);
    logic [7:0]  q[$];
    logic [35:0] k;
    int          sent;
    int          r;
    int          style;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        rand_fields();
        st_action = 2'd3;
        push();
      end else if (r < 7) begin
        write_param($urandom_range(0, ParamDepth - 1), $urandom);
      end else begin
        q.delete();
        repeat ($urandom_range(1, 4)) begin
          k = pick_key();
          add_entry(q, k, pick_value(k));
        end
        r = $urandom_range(0, 99);
        style = (r < 80) ? 0 : (r < 88) ? 1 : (r < 94) ? 2 : 3;
        send_record(q, style);
        sent += q.size() + 4;
      end
    end
  endtask

  initial begin
    logic [7:0] q[$];
    int         n;
    hold_req   = 0;
    burst_left = 0;
    nrules     = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < ParamDepth; i++)
      write_param(i, ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 3)) : $urandom);

    // directed: one rule per op, hash words, empty and overrunning records
    load_rules(16, 1);
    settle();
    set_rules_in_use(9'd16);
    for (int i = 0; i < 16; i++) begin
      q.delete();
      add_entry(q, tb_keys[i],
                ($urandom_range(0, 1) != 0) ? tb_params[tb_first[i]] : $urandom);
      send_record(q, 0);
    end
    q.delete();
    for (int h = 0; h < 4; h++) add_entry(q, HashFirst + 36'(h), $urandom);
    send_record(q, 0);
    send_record(q, 2);
    q.delete();
    for (int h = 0; h < 4; h++) add_entry(q, HashFirst + 36'(h), $urandom);
    send_record(q, 1);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       n = 0;
        1:       n = 1;
        2:       n = 256;
        3:       n = 511;
        4:       n = $urandom_range(2, 64);
        default: n = $urandom_range(2, 40);
      endcase
      if (n <= RuleDepth) load_rules(n, 0);
      settle();
      set_rules_in_use(9'(n));
      if (p == 2) hold_req = 1;
      random_records((p == 2 || p == 3) ? 60 : 40);
      settle();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
